// ----- rtl/pfls_pkg.sv -----
// ----------------------------------------------------------------------------
// pfls_pkg
// Types, constants and codes shared by the per-frame linear suballocator.
// ----------------------------------------------------------------------------
package pfls_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORD_W    = 32;
  localparam int STEP_W    = $clog2(WORD_W);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_BEGIN = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SLOT = 2'd1,
    STAT_BAD_ARG  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ALIGN,
    ST_END,
    ST_EVAL,
    ST_GROW,
    ST_DONE
  } state_t;

  // remainder unit handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // slot table write request
  typedef struct packed {
    logic              cursor_en;
    logic              cap_en;
    logic [SLOT_W-1:0] idx;
    logic [WORD_W-1:0] cursor;
    logic [WORD_W-1:0] cap;
  } slot_wr_t;

endpackage

// ----- rtl/pfls_rem_unit.sv -----
// ----------------------------------------------------------------------------
// pfls_rem_unit
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfls_rem_unit import pfls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [WORD_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W:0]   trial;

  assign trial = {rem_r, quo_r[WORD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = quo_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = WORD_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[WORD_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/pfls_slot_file.sv -----
// ----------------------------------------------------------------------------
// pfls_slot_file
// Per-slot cursor and capacity registers, one read and one write port.
// ----------------------------------------------------------------------------
module pfls_slot_file import pfls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_idx,
  input  slot_wr_t          wr,
  output logic [WORD_W-1:0] rd_cursor,
  output logic [WORD_W-1:0] rd_cap
);

  logic [WORD_W-1:0] cursor_r [NUM_SLOTS];
  logic [WORD_W-1:0] cap_r    [NUM_SLOTS];
  logic              rd_ok;

  // index codes past the last slot read as zero
  assign rd_ok = ({1'b0, rd_idx} < (SLOT_W+1)'(NUM_SLOTS));

  always_comb begin
    rd_cursor = '0;
    rd_cap    = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (rd_ok && rd_idx == SLOT_W'(i)) begin
        rd_cursor = cursor_r[i];
        rd_cap    = cap_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!rst_n) begin
        cursor_r[i] <= '0;
        cap_r[i]    <= '0;
      end else if (wr.idx == SLOT_W'(i)) begin
        if (wr.cursor_en) begin
          cursor_r[i] <= wr.cursor;
        end
        if (wr.cap_en) begin
          cap_r[i] <= wr.cap;
        end
      end
    end
  end

endmodule

// ----- rtl/per_frame_linear_suballocator.sv -----
// Begin and rejected requests go from ST_CHECK straight to ST_DONE;
//   allocations pass ST_DIV, ST_ALIGN, ST_END, ST_EVAL, and growth ST_GROW.
// One request at a time; the 32-step remainder unit sets an allocation's pace.
// in_ready returns only once the result has moved into the output register.
// Reset (rst_n, synchronous, active low) clears all slots, initial capacity
//   and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// per_frame_linear_suballocator
// Bump allocator with alignment over a small set of frame slots. Each slot
// holds a cursor and a capacity, grown on demand by doubling or snapped to fit.
// ----------------------------------------------------------------------------
module per_frame_linear_suballocator import pfls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [2:0]  in_slot_index,
  input  logic [31:0] in_alloc_size,
  input  logic [31:0] in_align_bytes,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [31:0] out_offset,
  output logic        out_grew,
  output logic [31:0] out_slot_capacity,
  output logic [31:0] out_slot_used,
  // initial capacity register
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // latched request
  logic              type_r, type_nxt;
  logic [2:0]        slot_r, slot_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  logic [WORD_W-1:0] align_r, align_nxt;

  // address arithmetic, one add per cycle
  logic [WORD_W-1:0] pad_r, pad_nxt;         // distance to next aligned offset
  logic [WORD_W:0]   aligned_r, aligned_nxt; // cursor rounded up
  logic [WORD_W+1:0] end_r, end_nxt;         // aligned + size
  logic [WORD_W-1:0] tgt_r, tgt_nxt;         // growth target

  // parked result, waits here while the output register is still full
  logic              res_ok_r, res_ok_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [WORD_W-1:0] res_offset_r, res_offset_nxt;
  logic              res_grew_r, res_grew_nxt;
  logic [WORD_W-1:0] res_cap_r, res_cap_nxt;
  logic [WORD_W-1:0] res_used_r, res_used_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [WORD_W-1:0] out_offset_r, out_offset_nxt;
  logic              out_grew_r, out_grew_nxt;
  logic [WORD_W-1:0] out_cap_r, out_cap_nxt;
  logic [WORD_W-1:0] out_used_r, out_used_nxt;

  logic [WORD_W-1:0] init_cap_r;

  // sub-unit wiring
  logic              div_start;
  div_stat_t         div_stat;
  logic [WORD_W-1:0] div_rem;
  slot_wr_t          slot_wr;
  logic [WORD_W-1:0] rd_cursor, rd_cap;

  logic              in_xfer, out_free;
  logic              bad_slot, bad_arg, overflow, fits;
  logic [WORD_W-1:0] end32;
  logic              grow_done;
  logic [WORD_W-1:0] grow_cap;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign bad_slot = ({1'b0, slot_r} >= 4'(NUM_SLOTS));
  assign bad_arg  = (size_r == '0) || (align_r == '0);
  assign overflow = (end_r[WORD_W+1:WORD_W] != 2'b00);
  assign end32    = end_r[WORD_W-1:0];
  assign fits     = (end32 <= rd_cap) && (rd_cap != '0);

  // doubling stops once the target covers the end; past half range it snaps
  assign grow_done = (tgt_r >= end32) || tgt_r[WORD_W-1];
  assign grow_cap  = (tgt_r >= end32) ? tgt_r : end32;

  pfls_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd_cursor),
    .divisor   (align_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  pfls_slot_file u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (slot_r[SLOT_W-1:0]),
    .wr        (slot_wr),
    .rd_cursor (rd_cursor),
    .rd_cap    (rd_cap)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bad_slot || type_r == REQ_BEGIN || bad_arg) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: state_nxt = ST_END;
      ST_END:   state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (overflow || fits) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        if (grow_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    type_nxt       = type_r;
    slot_nxt       = slot_r;
    size_nxt       = size_r;
    align_nxt      = align_r;
    pad_nxt        = pad_r;
    aligned_nxt    = aligned_r;
    end_nxt        = end_r;
    tgt_nxt        = tgt_r;
    res_ok_nxt     = res_ok_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    res_grew_nxt   = res_grew_r;
    res_cap_nxt    = res_cap_r;
    res_used_nxt   = res_used_r;
    div_start      = 1'b0;
    slot_wr        = '0;
    slot_wr.idx    = slot_r[SLOT_W-1:0];

    // result channel drains independently of the sequencer
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ok_nxt     = out_ok_r;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_grew_nxt   = out_grew_r;
    out_cap_nxt    = out_cap_r;
    out_used_nxt   = out_used_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          type_nxt  = in_req_type;
          slot_nxt  = in_slot_index;
          size_nxt  = in_alloc_size;
          align_nxt = in_align_bytes;
        end
      end
      ST_CHECK: begin
        res_ok_nxt     = 1'b0;
        res_offset_nxt = '0;
        res_grew_nxt   = 1'b0;
        res_cap_nxt    = rd_cap;
        res_used_nxt   = rd_cursor;
        if (bad_slot) begin
          res_status_nxt = STAT_BAD_SLOT;
          res_cap_nxt    = '0;
          res_used_nxt   = '0;
        end else if (type_r == REQ_BEGIN) begin
          // rewind the cursor, capacity stays
          slot_wr.cursor_en = 1'b1;
          slot_wr.cursor    = '0;
          res_ok_nxt        = 1'b1;
          res_status_nxt    = STAT_OK;
          res_used_nxt      = '0;
        end else if (bad_arg) begin
          res_status_nxt = STAT_BAD_ARG;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          pad_nxt = (div_rem == '0) ? '0 : align_r - div_rem;
        end
      end
      ST_ALIGN: begin
        aligned_nxt = {1'b0, rd_cursor} + {1'b0, pad_r};
      end
      ST_END: begin
        end_nxt = {1'b0, aligned_r} + {2'b00, size_r};
      end
      ST_EVAL: begin
        res_grew_nxt = 1'b0;
        res_cap_nxt  = rd_cap;
        if (overflow) begin
          res_ok_nxt     = 1'b0;
          res_status_nxt = STAT_OVERFLOW;
          res_offset_nxt = '0;
          res_used_nxt   = rd_cursor;
        end else if (fits) begin
          slot_wr.cursor_en = 1'b1;
          slot_wr.cursor    = end32;
          res_ok_nxt        = 1'b1;
          res_status_nxt    = STAT_OK;
          res_offset_nxt    = aligned_r[WORD_W-1:0];
          res_used_nxt      = end32;
        end else begin
          // seed: current capacity, else configured start, else exact fit
          if (rd_cap != '0) begin
            tgt_nxt = rd_cap;
          end else if (init_cap_r != '0) begin
            tgt_nxt = init_cap_r;
          end else begin
            tgt_nxt = end32;
          end
        end
      end
      ST_GROW: begin
        if (grow_done) begin
          slot_wr.cursor_en = 1'b1;
          slot_wr.cursor    = end32;
          slot_wr.cap_en    = 1'b1;
          slot_wr.cap       = grow_cap;
          res_ok_nxt        = 1'b1;
          res_status_nxt    = STAT_OK;
          res_offset_nxt    = aligned_r[WORD_W-1:0];
          res_grew_nxt      = (rd_cap != '0);
          res_cap_nxt       = grow_cap;
          res_used_nxt      = end32;
        end else begin
          tgt_nxt = tgt_r << 1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = res_ok_r;
          out_status_nxt = res_status_r;
          out_offset_nxt = res_offset_r;
          out_grew_nxt   = res_grew_r;
          out_cap_nxt    = res_cap_r;
          out_used_nxt   = res_used_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      init_cap_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        init_cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    slot_r       <= slot_nxt;
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    pad_r        <= pad_nxt;
    aligned_r    <= aligned_nxt;
    end_r        <= end_nxt;
    tgt_r        <= tgt_nxt;
    res_ok_r     <= res_ok_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    res_grew_r   <= res_grew_nxt;
    res_cap_r    <= res_cap_nxt;
    res_used_r   <= res_used_nxt;
    out_ok_r     <= out_ok_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_grew_r   <= out_grew_nxt;
    out_cap_r    <= out_cap_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_status        = out_status_r;
  assign out_offset        = out_offset_r;
  assign out_grew          = out_grew_r;
  assign out_slot_capacity = out_cap_r;
  assign out_slot_used     = out_used_r;

endmodule

// ----- rtl/pfls_checker.sv -----
// ----------------------------------------------------------------------------
// pfls_checker
// Port-level checks for the per-frame linear suballocator.
// ----------------------------------------------------------------------------
module pfls_checker import pfls_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [1:0]  out_status,
  input logic [31:0] out_offset,
  input logic        out_grew,
  input logic [31:0] out_slot_capacity,
  input logic [31:0] out_slot_used
);

  // a stalled result stays valid and holds its offset and used count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) && $stable(out_slot_used))
    else $error("stalled result changed");

  // ok and status agree
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok == (out_status == STAT_OK)))
    else $error("ok and status disagree");

  // failures grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_offset == '0 && !out_grew)
    else $error("failed request reports a grant");

  // a bad slot reports an empty slot
  a_bad_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BAD_SLOT |->
      out_slot_capacity == '0 && out_slot_used == '0)
    else $error("bad slot reports state");

  // the cursor never passes the capacity
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slot_used <= out_slot_capacity)
    else $error("cursor beyond capacity");

endmodule

bind per_frame_linear_suballocator pfls_checker u_pfls_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ok            (out_ok),
  .out_status        (out_status),
  .out_offset        (out_offset),
  .out_grew          (out_grew),
  .out_slot_capacity (out_slot_capacity),
  .out_slot_used     (out_slot_used)
);

// ----- verif/per_frame_linear_suballocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_frame_linear_suballocator_tb
// Self-checking bench for the per-frame bump allocator. A slot ledger class
// mirrors every slot's cursor and capacity and predicts each grant. Requests
// and grants move over valid/ready with random bursts and receiver stalls.
// ----------------------------------------------------------------------------
module per_frame_linear_suballocator_tb;
  import pfls_pkg::*;

  // one request as seen on the input channel
  typedef struct packed {
    logic        req_type;
    logic [2:0]  slot;
    logic [31:0] size;
    logic [31:0] align;
  } alloc_req_t;

  // one grant as seen on the result channel
  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [31:0] offset;
    logic        grew;
    logic [31:0] cap;
    logic [31:0] used;
  } grant_t;

  // Ledger of slot cursors and capacities; predicts grants in request order.
  class slot_ledger;
    logic [31:0] init_cap;
    logic [31:0] cursor_tab[NUM_SLOTS];
    logic [31:0] cap_tab[NUM_SLOTS];
    grant_t      grant_q[$];
    int          bad_count;

    function new();
      init_cap  = '0;
      bad_count = 0;
      foreach (cursor_tab[i]) begin
        cursor_tab[i] = '0;
        cap_tab[i]    = '0;
      end
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function void record_request(alloc_req_t r);
      grant_t      g;
      logic [63:0] cur, rem, aligned, end_pos, target;
      int          s;
      g = '0;
      g.status = STAT_OK;
      s = int'(r.slot);
      if (r.slot >= NUM_SLOTS) begin
        g.status = STAT_BAD_SLOT;
      end else if (r.req_type == REQ_BEGIN) begin
        cursor_tab[s] = '0;
        g.ok  = 1'b1;
        g.cap = cap_tab[s];
      end else if (r.size == 0 || r.align == 0) begin
        g.status = STAT_BAD_ARG;
        g.cap    = cap_tab[s];
        g.used   = cursor_tab[s];
      end else begin
        cur     = {32'd0, cursor_tab[s]};
        rem     = cur % {32'd0, r.align};
        aligned = (rem == 0) ? cur : cur + ({32'd0, r.align} - rem);
        end_pos = aligned + {32'd0, r.size};
        if (end_pos > 64'hFFFF_FFFF) begin
          g.status = STAT_OVERFLOW;
          g.cap    = cap_tab[s];
          g.used   = cursor_tab[s];
        end else begin
          if (!(end_pos <= {32'd0, cap_tab[s]} && cap_tab[s] != 0)) begin
            target = (cap_tab[s] != 0) ? {32'd0, cap_tab[s]} : {32'd0, init_cap};
            if (target == 0) target = end_pos;
            // doubling; past half range it snaps to the end, which exits the loop
            while (target < end_pos) begin
              if (target > 64'h7FFF_FFFF) target = end_pos;
              else target = target << 1;
            end
            g.grew     = (cap_tab[s] != 0);
            cap_tab[s] = target[31:0];
          end
          cursor_tab[s] = end_pos[31:0];
          g.ok     = 1'b1;
          g.offset = aligned[31:0];
          g.cap    = cap_tab[s];
          g.used   = cursor_tab[s];
        end
      end
      grant_q.push_back(g);
    endfunction

    function void diff_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        bad_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void compare_grant(grant_t a);
      grant_t e;
      if (grant_q.size() == 0) begin
        bad_count++;
        $display("%0t: grant with no pending request, expected none, actual %h",
                 $time, a);
        return;
      end
      e = grant_q.pop_front();
      diff_field("ok",            {31'd0, e.ok},     {31'd0, a.ok});
      diff_field("status",        {30'd0, e.status}, {30'd0, a.status});
      diff_field("offset",        e.offset,          a.offset);
      diff_field("grew",          {31'd0, e.grew},   {31'd0, a.grew});
      diff_field("slot_capacity", e.cap,             a.cap);
      diff_field("slot_used",     e.used,            a.used);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_req_type    = 1'b0;
  logic [2:0]  in_slot_index  = '0;
  logic [31:0] in_alloc_size  = '0;
  logic [31:0] in_align_bytes = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_ok;
  logic [1:0]  out_status;
  logic [31:0] out_offset;
  logic        out_grew;
  logic [31:0] out_slot_capacity;
  logic [31:0] out_slot_used;
  logic        cfg_we         = 1'b0;
  logic [31:0] cfg_wdata      = '0;

  slot_ledger ledger = new();

  // stimulus asks the receiver for one long hold-off; receiver clears it
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  per_frame_linear_suballocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_slot_index     (in_slot_index),
    .in_alloc_size     (in_alloc_size),
    .in_align_bytes    (in_align_bytes),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_status        (out_status),
    .out_offset        (out_offset),
    .out_grew          (out_grew),
    .out_slot_capacity (out_slot_capacity),
    .out_slot_used     (out_slot_used),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The grant side is
  // checked before the new request is noted; a request never yields its own
  // grant in the same cycle, so this order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        ledger.compare_grant('{ok: out_ok, status: status_t'(out_status),
                               offset: out_offset, grew: out_grew,
                               cap: out_slot_capacity, used: out_slot_used});
      if (in_valid && in_ready)
        ledger.record_request('{req_type: in_req_type, slot: in_slot_index,
                                size: in_alloc_size, align: in_align_bytes});
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: segments of always-ready, coin-flip, and a periodic stall
  // pattern. A long hold request overrides everything until its hold counter
  // runs out, so the block parks a grant and backs up the request channel.
  // --------------------------------------------------------------------------
  initial begin
    int seg_left;
    int seg_mode;
    int hold_cnt;
    seg_left = 0;
    seg_mode = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt == 0 && long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt      = 400;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (seg_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= (seg_left[2:0] >= 3'd3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all are entered and left just after a falling edge
  // --------------------------------------------------------------------------

  // offer one request and hold it until the transfer happens
  task automatic drive_request(logic t, logic [2:0] s, logic [31:0] sz, logic [31:0] al);
    in_valid       <= 1'b1;
    in_req_type    <= t;
    in_slot_index  <= s;
    in_alloc_size  <= sz;
    in_align_bytes <= al;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // sender stays quiet until every outstanding grant has been seen
  task automatic wait_for_grants();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  // register write only when the block is idle; an idle wait after the
  // last grant keeps clear of the output stage
  task automatic write_initial_capacity(logic [31:0] v);
    wait_for_grants();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we          <= 1'b0;
    ledger.init_cap  = v;
  endtask

  // sizes mostly small so slots live a while between rewinds
  function automatic logic [31:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)      return $urandom_range(1, 256);
    else if (sel <= 7) return $urandom_range(1, 1 << 20);
    else if (sel == 8) return $urandom;
    else               return $urandom | 32'h8000_0000;
  endfunction

  // powers of two dominate, odd and huge alignments mixed in
  function automatic logic [31:0] pick_align();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)      return 32'd1 << $urandom_range(0, 12);
    else if (sel <= 7) return $urandom_range(1, 1000);
    else if (sel == 8) return $urandom;
    else               return 32'hFFFF_FFFF;
  endfunction

  // Random phase: mostly well-formed allocations on live slots, some frame
  // rewinds, plus bad slots and zero size/alignment as noise. The first
  // stretch of each phase runs without sender gaps.
  task automatic run_random_phase(int n_items, int hold_at, int drain_at);
    int       burst_left;
    int       kind;
    logic     t;
    logic [2:0]  s;
    logic [31:0] sz, al;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      if (i == drain_at) wait_for_grants();
      if (i >= 40) begin
        if (burst_left == 0) begin
          idle_cycles($urandom_range(1, 20));
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
      end
      kind = $urandom_range(0, 99);
      t  = REQ_ALLOC;
      s  = 3'($urandom_range(0, NUM_SLOTS - 1));
      sz = pick_size();
      al = pick_align();
      if (kind < 12) begin
        // frame rewind; size and alignment are don't-care
        t  = REQ_BEGIN;
        sz = $urandom;
        al = $urandom;
      end else if (kind < 16) begin
        t  = 1'($urandom_range(0, 1));
        s  = 3'($urandom_range(NUM_SLOTS, 7));
        sz = $urandom;
        al = $urandom;
      end else if (kind < 21) begin
        case ($urandom_range(0, 2))
          0: sz = '0;
          1: al = '0;
          default: begin
            sz = '0;
            al = '0;
          end
        endcase
      end
      drive_request(t, s, sz, al);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] phase_caps[6];
    phase_caps = '{32'h0000_0040, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0, 32'h8000_0000, 32'h0000_0001};
    phase_caps[3] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: slot 0 with the reset initial capacity (exact fit) ---
    drive_request(REQ_BEGIN, 3'd0, 32'd0, 32'd0);             // rewind an empty slot
    drive_request(REQ_ALLOC, 3'd0, 32'd0, 32'd4);             // zero size
    drive_request(REQ_ALLOC, 3'd0, 32'd8, 32'd0);             // zero alignment
    drive_request(REQ_ALLOC, 3'd0, 32'd1, 32'd1);             // first store, no grew
    drive_request(REQ_ALLOC, 3'd0, 32'd3, 32'd4);             // align up, double 1 -> 8
    drive_request(REQ_ALLOC, 3'd0, 32'hC000_0000, 32'd1);     // doubling snaps to end
    drive_request(REQ_ALLOC, 3'd0, 32'h4000_0000, 32'd1);     // end past 32 bits
    drive_request(REQ_ALLOC, 3'd0, 32'd1, 32'hFFFF_FFFF);     // round-up pushes past 32 bits
    drive_request(REQ_BEGIN, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_request(REQ_ALLOC, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // largest region
    drive_request(REQ_ALLOC, 3'd4, 32'd16, 32'd4);            // bad slot, allocate
    drive_request(REQ_BEGIN, 3'd7, 32'd0, 32'd0);             // bad slot, begin
    drive_request(REQ_ALLOC, 3'd5, 32'd0, 32'd0);             // bad slot wins over zero args

    // --- slot 1: initial capacity of one byte doubles up ---
    write_initial_capacity(32'h0000_0001);
    drive_request(REQ_ALLOC, 3'd1, 32'd5, 32'd3);
    drive_request(REQ_ALLOC, 3'd1, 32'd7, 32'hAAAA_AAAA);     // odd alignment, snap
    drive_request(REQ_BEGIN, 3'd1, 32'd0, 32'd0);
    drive_request(REQ_ALLOC, 3'd1, 32'h10, 32'h10);           // fits, store kept

    // --- slot 2: initial capacity at half range, short of the end ---
    write_initial_capacity(32'h8000_0000);
    drive_request(REQ_ALLOC, 3'd2, 32'h9000_0000, 32'd2);
    drive_request(REQ_ALLOC, 3'd2, 32'd1, 32'd1);             // snap from an existing store

    // --- slot 3: initial capacity at full range ---
    write_initial_capacity(32'hFFFF_FFFF);
    drive_request(REQ_ALLOC, 3'd3, 32'd1, 32'd8);
    drive_request(REQ_BEGIN, 3'd3, 32'h1234_5678, 32'h8765_4321);
    drive_request(REQ_ALLOC, 3'd3, 32'hFFFF_FFFF, 32'd1);

    // --- random phases, one register setting each ---
    for (int p = 0; p < 6; p++) begin
      write_initial_capacity(phase_caps[p]);
      run_random_phase(272,
                       (p == 1 || p == 4) ? 100 : -1,
                       (p == 2 || p == 3) ? 150 : -1);
    end

    // drain, then leave time for any stray grant to show up
    wait_for_grants();
    repeat (100) @(negedge clk);
    if (ledger.bad_count == 0 && ledger.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- per_frame_linear_suballocator.f -----
rtl/pfls_pkg.sv
rtl/pfls_rem_unit.sv
rtl/pfls_slot_file.sv
rtl/per_frame_linear_suballocator.sv
rtl/pfls_checker.sv
verif/per_frame_linear_suballocator_tb.sv
